// ----- rtl/core/pwos_pkg.sv -----
package pwos_pkg;

    localparam int MaxObstacles = 8;
    localparam int MaxWaypoints = 16;
    localparam int CoordBits    = 6;

    localparam int ObsBits    = $clog2(MaxObstacles);
    localparam int WpBits     = $clog2(MaxWaypoints);
    localparam int CountBits  = ObsBits + 1;
    localparam int PendBits   = WpBits + 1;
    localparam int StoreBits  = ObsBits + WpBits;
    localparam int PeriodBits = 16;
    localparam int TickBits   = 32;
    localparam int DimBits    = 7;
    localparam int KindBits   = 2;
    localparam int EventBits  = 3;
    localparam int CfgIdxBits = 1;

    localparam logic [KindBits-1:0] KindTick   = 2'd0;
    localparam logic [KindBits-1:0] KindAppend = 2'd1;
    localparam logic [KindBits-1:0] KindCommit = 2'd2;

    localparam logic [CfgIdxBits-1:0] CfgGridWidth  = 1'd0;
    localparam logic [CfgIdxBits-1:0] CfgGridHeight = 1'd1;

    localparam logic [DimBits-1:0] GridReset = 7'd64;

    typedef enum logic [EventBits-1:0] {
        EV_NONE     = 3'd0,
        EV_VACATED  = 3'd1,
        EV_OCCUPIED = 3'd2,
        EV_TAKEN    = 3'd3,
        EV_SHORT    = 3'd4,
        EV_PERIOD   = 3'd5,
        EV_BOUNDS   = 3'd6,
        EV_FULL     = 3'd7
    } t_event;

endpackage

// ----- rtl/core/pwos_in_if.sv -----
interface pwos_in_if;
    import pwos_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KindBits-1:0]   kind;
    logic [CoordBits-1:0]  cell_x;
    logic [CoordBits-1:0]  cell_y;
    logic [PeriodBits-1:0] ticks_per_step;

    modport source (output valid, kind, cell_x, cell_y, ticks_per_step, input ready);
    modport sink   (input valid, kind, cell_x, cell_y, ticks_per_step, output ready);
endinterface

// ----- rtl/core/pwos_out_if.sv -----
interface pwos_out_if;
    import pwos_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [EventBits-1:0] event_res;
    logic [CoordBits-1:0] out_x;
    logic [CoordBits-1:0] out_y;
    logic [ObsBits-1:0]   mover_index;
    logic [TickBits-1:0]  ticks_seen;
    logic                 last;

    modport source (output valid, event_res, out_x, out_y, mover_index, ticks_seen, last,
                    input ready);
    modport sink   (input valid, event_res, out_x, out_y, mover_index, ticks_seen, last,
                    output ready);
endinterface

// ----- rtl/core/periodic_waypoint_obstacle_sequencer.sv -----
// Channel   Dir  Handshake     Payload
// i_item    in   valid/ready   kind, cell_x, cell_y, ticks_per_step
// o_res     out  valid/ready   event_res, out_x, out_y, mover_index, ticks_seen, last
// cfg       in   i_cfg_we      i_cfg_idx, i_cfg_wdata (0 grid_width, 1 grid_height)
//
// One transaction at a time; ready is high only while idle.
// Append, reject and unused kinds go from idle to S_END; an accepted commit passes S_CRD first.
// Tick: per installed mover, S_TEV (no step) or S_TEV, S_TV and S_TO (step), then S_END,
// with the mover record memory and waypoint memory read through registers.
// A full output register stalls the sequencer; the next transaction is taken
// while the final result still waits. Reset is synchronous, no clearing pass.
module periodic_waypoint_obstacle_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pwos_in_if.sink                            i_item,
    pwos_out_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [pwos_pkg::CfgIdxBits-1:0]    i_cfg_idx,
    input  logic [pwos_pkg::DimBits-1:0]       i_cfg_wdata
);
    import pwos_pkg::*;

    typedef struct packed {
        logic [PendBits-1:0]   len;
        logic [PeriodBits-1:0] period;
        logic [PeriodBits-1:0] elapsed;
        logic [WpBits-1:0]     pos;
    } t_mover;

    typedef struct packed {
        t_event               ev;
        logic [CoordBits-1:0] x;
        logic [CoordBits-1:0] y;
        logic [ObsBits-1:0]   idx;
    } t_hold;

    typedef enum logic [2:0] {
        S_IDLE, S_CRD, S_TEV, S_TV, S_TO, S_END
    } t_state;

    // memories
    logic [2*CoordBits-1:0] wp_mem [MaxObstacles*MaxWaypoints];
    t_mover                 mv_mem [MaxObstacles];

    t_state                 r_state;
    logic                   r_out_valid;
    t_hold                  r_out;
    logic [TickBits-1:0]    r_out_ticks;
    logic                   r_out_last;
    t_hold                  r_hold;
    logic                   r_hold_v;
    logic [PendBits-1:0]    r_pend_len;
    logic                   r_pend_bad;
    logic [CountBits-1:0]   r_mover_count;
    logic [TickBits-1:0]    r_tick;
    logic [DimBits-1:0]     r_grid_w;
    logic [DimBits-1:0]     r_grid_h;
    logic [ObsBits-1:0]     r_idx;
    logic [WpBits-1:0]      r_newpos;
    logic [2*CoordBits-1:0] r_wp_rd;
    t_mover                 r_mv_rd;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic                   movers_full;
    logic                   pend_full;
    logic                   cell_bad;
    logic                   commit_ok;
    t_event                 commit_ev;
    logic                   more;
    logic                   step;
    logic                   proceed_tv;
    logic [PeriodBits-1:0]  el_n;
    logic [PendBits-1:0]    pos_n;
    logic [WpBits-1:0]      newpos;

    logic                   wp_we;
    logic [StoreBits-1:0]   wp_waddr;
    logic                   wp_re;
    logic [StoreBits-1:0]   wp_raddr;
    logic                   mv_we;
    logic [ObsBits-1:0]     mv_waddr;
    t_mover                 mv_wdata;
    logic                   mv_re;
    logic [ObsBits-1:0]     mv_raddr;

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_res.ready;
    assign proceed_tv   = !r_hold_v || out_free;
    assign out_load     = ((r_state == S_TV) && proceed_tv && r_hold_v) ||
                          (((r_state == S_TO) || (r_state == S_END)) && out_free);

    assign movers_full = (r_mover_count >= CountBits'(MaxObstacles));
    assign pend_full   = (r_pend_len >= PendBits'(MaxWaypoints));
    assign cell_bad    = (DimBits'(i_item.cell_x) >= r_grid_w) ||
                         (DimBits'(i_item.cell_y) >= r_grid_h);
    assign commit_ok   = !movers_full && (r_pend_len >= PendBits'(2)) &&
                         (i_item.ticks_per_step != '0) && !r_pend_bad;

    always_comb begin
        priority if (movers_full) begin
            commit_ev = EV_FULL;
        end else if (r_pend_len < PendBits'(2)) begin
            commit_ev = EV_SHORT;
        end else if (i_item.ticks_per_step == '0) begin
            commit_ev = EV_PERIOD;
        end else begin
            commit_ev = EV_BOUNDS;
        end
    end

    assign more   = ({1'b0, r_idx} + CountBits'(1)) < r_mover_count;
    assign el_n   = r_mv_rd.elapsed + PeriodBits'(1);
    assign step   = !(el_n < r_mv_rd.period);
    assign pos_n  = {1'b0, r_mv_rd.pos} + PendBits'(1);
    assign newpos = ((pos_n >= r_mv_rd.len) || (pos_n >= PendBits'(MaxWaypoints))) ?
                    '0 : pos_n[WpBits-1:0];

    always_comb begin
        wp_we    = accept && (i_item.kind == KindAppend) && !movers_full && !pend_full;
        wp_waddr = {r_mover_count[ObsBits-1:0], r_pend_len[WpBits-1:0]};
        wp_re    = 1'b0;
        wp_raddr = {r_mover_count[ObsBits-1:0], {WpBits{1'b0}}};
        mv_we    = 1'b0;
        mv_waddr = r_idx;
        mv_wdata = r_mv_rd;
        mv_re    = 1'b0;
        mv_raddr = r_idx + ObsBits'(1);
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_item.kind == KindCommit)) begin
                    wp_re = 1'b1;
                    if (commit_ok) begin
                        mv_we    = 1'b1;
                        mv_waddr = r_mover_count[ObsBits-1:0];
                        mv_wdata = '{len: r_pend_len, period: i_item.ticks_per_step,
                                     elapsed: '0, pos: '0};
                    end
                end
                if (accept && (i_item.kind == KindTick) && (r_mover_count != '0)) begin
                    mv_re    = 1'b1;
                    mv_raddr = '0;
                end
            end
            S_TEV: begin
                mv_we = 1'b1;
                if (step) begin
                    mv_wdata.elapsed = '0;
                    mv_wdata.pos     = newpos;
                    wp_re            = 1'b1;
                    wp_raddr         = {r_idx, r_mv_rd.pos};
                end else begin
                    mv_wdata.elapsed = el_n;
                    mv_re            = more;
                end
            end
            S_TV: begin
                wp_re    = proceed_tv;
                wp_raddr = {r_idx, r_newpos};
            end
            S_TO: begin
                mv_re = out_free && more;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wp_we) begin
            wp_mem[wp_waddr] <= {i_item.cell_x, i_item.cell_y};
        end
        if (wp_re) begin
            r_wp_rd <= wp_mem[wp_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv_we) begin
            mv_mem[mv_waddr] <= mv_wdata;
        end
        if (mv_re) begin
            r_mv_rd <= mv_mem[mv_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_hold_v      <= 1'b0;
            r_pend_len    <= '0;
            r_pend_bad    <= 1'b0;
            r_mover_count <= '0;
            r_tick        <= '0;
            r_grid_w      <= GridReset;
            r_grid_h      <= GridReset;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CfgGridWidth:  r_grid_w <= i_cfg_wdata;
                    CfgGridHeight: r_grid_h <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r_out_valid <= out_load || (r_out_valid && !o_res.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_item.kind)
                            KindTick: begin
                                r_tick   <= r_tick + TickBits'(1);
                                r_hold_v <= 1'b0;
                                r_idx    <= '0;
                                r_state  <= (r_mover_count != '0) ? S_TEV : S_END;
                            end
                            KindAppend: begin
                                r_hold_v <= 1'b1;
                                r_state  <= S_END;
                                if (movers_full || pend_full) begin
                                    r_hold <= t_hold'{ev: EV_FULL, x: '0, y: '0, idx: '0};
                                end else begin
                                    r_hold     <= t_hold'{ev: EV_TAKEN, x: i_item.cell_x,
                                                          y: i_item.cell_y, idx: '0};
                                    r_pend_len <= r_pend_len + PendBits'(1);
                                    if (cell_bad) begin
                                        r_pend_bad <= 1'b1;
                                    end
                                end
                            end
                            KindCommit: begin
                                r_pend_len <= '0;
                                r_pend_bad <= 1'b0;
                                if (commit_ok) begin
                                    r_hold_v <= 1'b0;
                                    r_state  <= S_CRD;
                                end else begin
                                    r_hold   <= t_hold'{ev: commit_ev, x: '0, y: '0,
                                                        idx: '0};
                                    r_hold_v <= 1'b1;
                                    r_state  <= S_END;
                                end
                            end
                            default: begin
                                r_hold   <= t_hold'{ev: EV_NONE, x: '0, y: '0, idx: '0};
                                r_hold_v <= 1'b1;
                                r_state  <= S_END;
                            end
                        endcase
                    end
                end
                S_CRD: begin
                    r_hold        <= '{ev: EV_OCCUPIED, x: r_wp_rd[2*CoordBits-1:CoordBits],
                                       y: r_wp_rd[CoordBits-1:0],
                                       idx: r_mover_count[ObsBits-1:0]};
                    r_hold_v      <= 1'b1;
                    r_mover_count <= r_mover_count + CountBits'(1);
                    r_state       <= S_END;
                end
                S_TEV: begin
                    if (step) begin
                        r_newpos <= newpos;
                        r_state  <= S_TV;
                    end else if (more) begin
                        r_idx <= r_idx + ObsBits'(1);
                    end else begin
                        r_state <= S_END;
                    end
                end
                S_TV: begin
                    if (proceed_tv) begin
                        if (r_hold_v) begin
                            r_out       <= r_hold;
                            r_out_ticks <= r_tick;
                            r_out_last  <= 1'b0;
                        end
                        r_hold   <= '{ev: EV_VACATED, x: r_wp_rd[2*CoordBits-1:CoordBits],
                                      y: r_wp_rd[CoordBits-1:0], idx: r_idx};
                        r_hold_v <= 1'b1;
                        r_state  <= S_TO;
                    end
                end
                S_TO: begin
                    if (out_free) begin
                        r_out       <= r_hold;
                        r_out_ticks <= r_tick;
                        r_out_last  <= 1'b0;
                        r_hold      <= '{ev: EV_OCCUPIED, x: r_wp_rd[2*CoordBits-1:CoordBits],
                                         y: r_wp_rd[CoordBits-1:0], idx: r_idx};
                        if (more) begin
                            r_idx   <= r_idx + ObsBits'(1);
                            r_state <= S_TEV;
                        end else begin
                            r_state <= S_END;
                        end
                    end
                end
                S_END: begin
                    if (out_free) begin
                        r_out       <= r_hold_v ? r_hold :
                                       t_hold'{ev: EV_NONE, x: '0, y: '0, idx: '0};
                        r_out_ticks <= r_tick;
                        r_out_last  <= 1'b1;
                        r_hold_v    <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.event_res   = r_out.ev;
    assign o_res.out_x       = r_out.x;
    assign o_res.out_y       = r_out.y;
    assign o_res.mover_index = r_out.idx;
    assign o_res.ticks_seen  = r_out_ticks;
    assign o_res.last        = r_out_last;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mover_count <= CountBits'(MaxObstacles))
        else $error("mover count above capacity");

    a_pend_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_len <= PendBits'(MaxWaypoints))
        else $error("pending list above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mover_count != $past(r_mover_count)) |->
        (r_mover_count == $past(r_mover_count) + CountBits'(1)))
        else $error("mover count moved by more than one");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("staged result left behind at idle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> $stable(r_out_last))
        else $error("output register overwritten while stalled");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pwos_pkg::*;

    localparam logic [KindBits-1:0] KindUnused = 2'd3;
    localparam int StoreDepth = MaxObstacles * MaxWaypoints;
    localparam int SettleCycles = 40;
    localparam int StallLimit = 4000;
    localparam int MaxLogged = 40;

    typedef struct packed {
        logic [KindBits-1:0]   kind;
        logic [CoordBits-1:0]  cell_x;
        logic [CoordBits-1:0]  cell_y;
        logic [PeriodBits-1:0] period;
    } t_item;

    typedef struct packed {
        logic [EventBits-1:0] ev;
        logic [CoordBits-1:0] x;
        logic [CoordBits-1:0] y;
        logic [ObsBits-1:0]   mover;
        logic [TickBits-1:0]  ticks;
        logic                 last;
    } t_cell_event;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxBits-1:0] cfg_idx;
    logic [DimBits-1:0] cfg_wdata;

    pwos_in_if  item_if ();
    pwos_out_if res_if ();

    periodic_waypoint_obstacle_sequencer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_if.sink),
        .o_res       (res_if.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    t_item       stim_q[$];
    t_cell_event cell_events_q[$];
    int          err_cnt = 0;
    int          queued = 0;
    bit          quiet = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          stall_cnt = 0;

    // predictor state
    logic [DimBits-1:0]    grid_w = GridReset;
    logic [DimBits-1:0]    grid_h = GridReset;
    logic [CoordBits-1:0]  route_x [StoreDepth];
    logic [CoordBits-1:0]  route_y [StoreDepth];
    int                    pend_len = 0;
    bit                    pend_bad = 1'b0;
    int                    movers = 0;
    int                    mv_len [MaxObstacles];
    logic [PeriodBits-1:0] mv_period [MaxObstacles];
    logic [PeriodBits-1:0] mv_elapsed [MaxObstacles];
    int                    mv_pos [MaxObstacles];
    logic [TickBits-1:0]   tick_cnt = '0;

    task automatic report(input string msg);
        err_cnt++;
        if (err_cnt <= MaxLogged) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic post_event(input t_event ev, input logic [CoordBits-1:0] x,
                              input logic [CoordBits-1:0] y, input int mover);
        t_cell_event e;
        e.ev    = ev;
        e.x     = x;
        e.y     = y;
        e.mover = mover[ObsBits-1:0];
        e.ticks = tick_cnt;
        e.last  = 1'b0;
        cell_events_q = {cell_events_q, e};
    endtask

    task automatic apply_item(input t_item it);
        int base;
        int pos;
        int n;
        n = cell_events_q.size();
        case (it.kind)
            KindTick: begin
                tick_cnt = tick_cnt + 1'b1;
                for (int i = 0; i < movers; i++) begin
                    mv_elapsed[i] = mv_elapsed[i] + 1'b1;
                    if (mv_elapsed[i] < mv_period[i]) continue;
                    mv_elapsed[i] = '0;
                    base = i * MaxWaypoints;
                    pos = mv_pos[i];
                    post_event(EV_VACATED, route_x[base + pos], route_y[base + pos], i);
                    pos++;
                    if (pos >= mv_len[i] || pos >= MaxWaypoints) pos = 0;
                    mv_pos[i] = pos;
                    post_event(EV_OCCUPIED, route_x[base + pos], route_y[base + pos], i);
                end
                if (cell_events_q.size() == n) post_event(EV_NONE, '0, '0, 0);
            end
            KindAppend: begin
                if (movers >= MaxObstacles || pend_len >= MaxWaypoints) begin
                    post_event(EV_FULL, '0, '0, 0);
                end else begin
                    route_x[movers * MaxWaypoints + pend_len] = it.cell_x;
                    route_y[movers * MaxWaypoints + pend_len] = it.cell_y;
                    pend_len++;
                    if (it.cell_x >= grid_w || it.cell_y >= grid_h) pend_bad = 1'b1;
                    post_event(EV_TAKEN, it.cell_x, it.cell_y, 0);
                end
            end
            KindCommit: begin
                if (movers >= MaxObstacles) begin
                    post_event(EV_FULL, '0, '0, 0);
                end else if (pend_len < 2) begin
                    post_event(EV_SHORT, '0, '0, 0);
                end else if (it.period == '0) begin
                    post_event(EV_PERIOD, '0, '0, 0);
                end else if (pend_bad) begin
                    post_event(EV_BOUNDS, '0, '0, 0);
                end else begin
                    base = movers * MaxWaypoints;
                    mv_len[movers] = pend_len;
                    mv_period[movers] = it.period;
                    mv_elapsed[movers] = '0;
                    mv_pos[movers] = 0;
                    post_event(EV_OCCUPIED, route_x[base], route_y[base], movers);
                    movers++;
                end
                pend_len = 0;
                pend_bad = 1'b0;
            end
            default: begin
                post_event(EV_NONE, '0, '0, 0);
            end
        endcase
        cell_events_q[cell_events_q.size() - 1].last = 1'b1;
    endtask

    // input side
    always @(posedge clk) begin
        t_item it;
        if (!rst_n) begin
            item_if.valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                it.kind   = item_if.kind;
                it.cell_x = item_if.cell_x;
                it.cell_y = item_if.cell_y;
                it.period = item_if.ticks_per_step;
                apply_item(it);
            end
            if (!item_if.valid || item_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    item_if.valid <= 1'b0;
                end else if (stim_q.size() == 0) begin
                    item_if.valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(1, 13) - 1;
                    item_if.valid <= 1'b0;
                end else begin
                    it = stim_q.pop_front();
                    item_if.kind           <= it.kind;
                    item_if.cell_x         <= it.cell_x;
                    item_if.cell_y         <= it.cell_y;
                    item_if.ticks_per_step <= it.period;
                    item_if.valid          <= 1'b1;
                end
            end
        end
    end

    // output side
    always @(posedge clk) begin
        t_cell_event got;
        t_cell_event want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.ev    = res_if.event_res;
                got.x     = res_if.out_x;
                got.y     = res_if.out_y;
                got.mover = res_if.mover_index;
                got.ticks = res_if.ticks_seen;
                got.last  = res_if.last;
                if (cell_events_q.size() == 0) begin
                    report($sformatf("unexpected transaction ev=%0d x=%0d y=%0d", got.ev,
                                     got.x, got.y));
                end else begin
                    want = cell_events_q.pop_front();
                    if (got !== want) begin
                        report($sformatf({"ev/x/y/mover/ticks/last got %0d/%0d/%0d/%0d/%0d/%0d",
                                          " want %0d/%0d/%0d/%0d/%0d/%0d"},
                                         got.ev, got.x, got.y, got.mover, got.ticks,
                                         got.last, want.ev, want.x, want.y, want.mover,
                                         want.ticks, want.last));
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                res_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 13) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
                stall_cnt = 0;
            end else begin
                stall_cnt++;
            end
            if (stall_cnt >= StallLimit) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic [KindBits-1:0] kind, input logic [CoordBits-1:0] x,
                              input logic [CoordBits-1:0] y, input logic [PeriodBits-1:0] per);
        t_item it;
        it.kind   = kind;
        it.cell_x = x;
        it.cell_y = y;
        it.period = per;
        stim_q = {stim_q, it};
        if (kind != KindUnused) queued++;
    endtask

    task automatic queue_tick();
        queue_item(KindTick, CoordBits'($urandom_range(0, 63)),
                   CoordBits'($urandom_range(0, 63)), PeriodBits'($urandom_range(0, 65535)));
    endtask

    function automatic logic [CoordBits-1:0] pick_coord(input int lim);
        if (lim == 0 || $urandom_range(0, 15) == 0) return CoordBits'($urandom_range(0, 63));
        if (lim > 64) lim = 64;
        return CoordBits'($urandom_range(0, lim - 1));
    endfunction

    task automatic queue_route(input int w, input int h);
        int n;
        int r;
        logic [PeriodBits-1:0] per;
        r = $urandom_range(0, 29);
        if (r == 0) n = $urandom_range(17, 18);
        else if (r < 5) n = MaxWaypoints;
        else n = $urandom_range(2, 5);
        for (int i = 0; i < n; i++) begin
            queue_item(KindAppend, pick_coord(w), pick_coord(h),
                       PeriodBits'($urandom_range(0, 65535)));
            if ($urandom_range(0, 5) == 0) queue_tick();
        end
        r = $urandom_range(0, 19);
        if (r == 0) per = '0;
        else if (r == 1) per = '1;
        else if (r < 5) per = PeriodBits'($urandom_range(0, 65535));
        else per = PeriodBits'($urandom_range(1, 4));
        queue_item(KindCommit, CoordBits'($urandom_range(0, 63)),
                   CoordBits'($urandom_range(0, 63)), per);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (stim_q.size() != 0 || item_if.valid || cell_events_q.size() != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic set_grid(input int w, input int h);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= CfgGridWidth;
        cfg_wdata <= w[DimBits-1:0];
        grid_w = w[DimBits-1:0];
        @(posedge clk);
        cfg_idx   <= CfgGridHeight;
        cfg_wdata <= h[DimBits-1:0];
        grid_h = h[DimBits-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input int w, input int h, input int target);
        int start;
        int r;
        set_grid(w, h);
        start = queued;
        while (queued - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                repeat ($urandom_range(1, 4)) queue_tick();
            end else if (r < 85) begin
                queue_route(w, h);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    queue_item(KindBits'($urandom_range(0, 3)),
                               CoordBits'($urandom_range(0, 63)),
                               CoordBits'($urandom_range(0, 63)),
                               PeriodBits'($urandom_range(0, 65535)));
                end
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CfgGridWidth;
        cfg_wdata = GridReset;
        item_if.valid = 1'b0;
        item_if.kind = KindTick;
        item_if.cell_x = '0;
        item_if.cell_y = '0;
        item_if.ticks_per_step = '0;
        res_if.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset grid: empty ticks, unused kind, short lists, full pending list
        queue_tick();
        queue_item(KindUnused, CoordBits'($urandom_range(0, 63)),
                   CoordBits'($urandom_range(0, 63)), 16'd9);
        queue_item(KindCommit, 6'd0, 6'd0, 16'd1);
        queue_item(KindAppend, 6'd63, 6'd63, 16'd0);
        queue_item(KindCommit, 6'd63, 6'd63, 16'hFFFF);
        for (int i = 0; i <= MaxWaypoints; i++) begin
            if (i == 0) queue_item(KindAppend, 6'd0, 6'd0, 16'hFFFF);
            else if (i == 1) queue_item(KindAppend, 6'd63, 6'd63, 16'd0);
            else queue_item(KindAppend, CoordBits'((i * 5) % 64), CoordBits'(63 - i * 3),
                            PeriodBits'($urandom_range(0, 65535)));
        end
        queue_item(KindCommit, 6'd21, 6'd42, 16'd0);

        // 1x1 grid: check precedence and install one mover
        set_grid(1, 1);
        queue_item(KindAppend, 6'd1, 6'd0, 16'd0);
        queue_item(KindAppend, 6'd0, 6'd1, 16'd0);
        queue_item(KindCommit, 6'd0, 6'd0, 16'd0);
        queue_item(KindAppend, 6'd1, 6'd1, 16'd0);
        queue_item(KindAppend, 6'd0, 6'd0, 16'd0);
        queue_item(KindCommit, 6'd0, 6'd0, 16'hFFFF);
        queue_item(KindAppend, 6'd0, 6'd0, 16'd0);
        queue_item(KindAppend, 6'd0, 6'd0, 16'd0);
        queue_item(KindCommit, 6'd63, 6'd63, 16'd1);
        queue_tick();

        run_phase(17, 40, 50);
        run_phase(1, 64, 50);
        run_phase(0, 127, 50);
        run_phase(127, 0, 50);
        run_phase(64, 64, 50);
        run_phase($urandom_range(1, 64), $urandom_range(1, 64), 50);
        run_phase(64, 1, 50);
        quiet = 1'b1;
        run_phase(64, 64, 50);

        wait_idle();
        if (cell_events_q.size() != 0) begin
            report($sformatf("%0d expected transactions never arrived", cell_events_q.size()));
        end
        if (err_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
